/* design/mscpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscpc_pkg
// Shared types, register indexes and reset values of the mains synced
// charger pulse controller.
// ----------------------------------------------------------------------------
package mscpc_pkg;

  localparam int unsigned AdcW    = 10;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned PhaseW  = 7;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 10;

  typedef enum logic [1:0] {
    MODE_TIMER = 2'd0,
    MODE_SYNC  = 2'd1,
    MODE_MAIN  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BATTERY_FULL      = 3'd0,
    REG_MIN_DRIVE_LEVEL   = 3'd1,
    REG_SAMPLE_PERIOD     = 3'd2,
    REG_LOW_BATTERY_PAUSE = 3'd3,
    REG_BLINK_PERIOD      = 3'd4,
    REG_LED_MIN_ON        = 3'd5,
    REG_SYNC_HOLDOFF      = 3'd6,
    REG_PHASE_PERIOD      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [AdcW-1:0]   battery_full;
    logic [LevelW-1:0] min_drive_level;
    logic [CountW-1:0] sample_period;
    logic [CountW-1:0] low_battery_pause;
    logic [CountW-1:0] blink_period;
    logic [CountW-1:0] led_min_on;
    logic [PhaseW-1:0] sync_holdoff;
    logic [PhaseW-1:0] phase_period;
  } cfg_t;

  localparam logic [AdcW-1:0]   RstBatteryFull    = 10'd900;
  localparam logic [LevelW-1:0] RstMinDriveLevel  = 8'd2;
  localparam logic [CountW-1:0] RstSamplePeriod   = 8'd200;
  localparam logic [CountW-1:0] RstLowBatteryPause = 8'd150;
  localparam logic [CountW-1:0] RstBlinkPeriod    = 8'd200;
  localparam logic [CountW-1:0] RstLedMinOn       = 8'd10;
  localparam logic [PhaseW-1:0] RstSyncHoldoff    = 7'd70;
  localparam logic [PhaseW-1:0] RstPhasePeriod    = 7'd85;
  localparam logic [CountW-1:0] RstPauseCount     = 8'd255;

  // x / 3 for 8-bit x via reciprocal 171 / 512
  function automatic logic [LevelW-1:0] div3(input logic [LevelW-1:0] x);
    logic [LevelW+8:0] prod;
    prod = {9'd0, x} * 17'd171;
    return prod[LevelW+8:9];
  endfunction

endpackage

/* design/mscpc_led.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscpc_led
// Indicator blink counter; on-time follows the battery sample on each
// main tick.
// ----------------------------------------------------------------------------
module mscpc_led (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             tick,
  input  logic                             sync_seen,
  input  logic [mscpc_pkg::AdcW-1:0]       battery_sample,
  input  mscpc_pkg::cfg_t                  cfg,
  output logic                             led_on_nxt
);

  logic [mscpc_pkg::CountW-1:0] led_count_r, led_count_nxt;
  logic                         led_state_r, led_state_nxt;
  logic [mscpc_pkg::CountW-1:0] cnt_inc;
  logic signed [11:0]           lower;
  logic signed [11:0]           diff;
  logic signed [11:0]           capped;
  logic [mscpc_pkg::CountW-1:0] on_time;

  always_comb begin
    lower  = $signed({2'b00, cfg.battery_full}) - $signed({4'b0000, cfg.blink_period});
    diff   = $signed({2'b00, battery_sample}) - lower;
    capped = diff;
    if (capped > $signed({4'b0000, cfg.blink_period})) begin
      capped = $signed({4'b0000, cfg.blink_period});
    end
    if (capped < $signed({4'b0000, cfg.led_min_on})) begin
      capped = $signed({4'b0000, cfg.led_min_on});
    end
    if (diff > 12'sd0) begin
      on_time = capped[mscpc_pkg::CountW-1:0];
    end else begin
      on_time = cfg.led_min_on;
    end
  end

  always_comb begin
    led_count_nxt = led_count_r;
    led_state_nxt = led_state_r;
    cnt_inc       = led_count_r;
    if (tick) begin
      if (led_count_r < cfg.blink_period) begin
        cnt_inc = led_count_r + 8'd1;
      end
      if (sync_seen) begin
        cnt_inc = '0;
      end
      led_count_nxt = cnt_inc;
      if (cnt_inc == '0) begin
        led_state_nxt = 1'b1;
      end
      if (cnt_inc > on_time) begin
        led_state_nxt = 1'b0;
      end
    end
  end

  assign led_on_nxt = led_state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= '0;
      led_state_r <= 1'b0;
    end else begin
      led_count_r <= led_count_nxt;
      led_state_r <= led_state_nxt;
    end
  end

endmodule

/* design/mains_synced_charger_pulse_control_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_synced_charger_pulse_control_core
// Charger drive-pulse controller locked to mains sync edges, with setpoint
// and battery sampling, low-battery pause and a charge indicator LED.
// ----------------------------------------------------------------------------
// Each input beat is a timer tick, a mains sync edge, a main tick or an idle
// beat (in_tuser). The beat updates all state in the cycle it is accepted;
// the output register holds its result, valid in the next cycle. One beat is
// taken every cycle; the only limit is out_tready, since a new beat is taken
// whenever the output register is empty or being drained in the same cycle.
// Configuration writes are taken every cycle and should happen while idle.
module mains_synced_charger_pulse_control_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [9:0] adc_value, [10] battery_low_pin, [15:11] zero
  input  logic [15:0]                      in_tdata,
  // [1:0] mode
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] drive_on, [1] led_on, [2] adc_channel, [3] sync_accepted, [7:4] zero
  output logic [7:0]                       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mscpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mscpc_pkg::CfgDatW-1:0]    cfg_data
);

  mscpc_pkg::cfg_t              cfg_r;
  mscpc_pkg::mode_t             mode;
  logic [mscpc_pkg::AdcW-1:0]   adc_value;
  logic                         low_pin;
  logic                         accept;

  logic [mscpc_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [mscpc_pkg::LevelW-1:0] latched_r, latched_nxt;
  logic [mscpc_pkg::LevelW-1:0] level_r, level_nxt;
  logic                         drive_r, drive_nxt;
  logic [mscpc_pkg::CountW-1:0] sample_r, sample_nxt;
  logic [mscpc_pkg::CountW-1:0] pause_r, pause_nxt;
  logic [mscpc_pkg::AdcW-1:0]   batt_r, batt_nxt;
  logic [mscpc_pkg::AdcW-1:0]   setp_r, setp_nxt;
  logic                         seen_r, seen_nxt;
  logic                         chan_r, chan_nxt;
  logic                         synced;
  logic                         led_nxt;

  logic [mscpc_pkg::PhaseW:0]   phase_inc;
  logic [mscpc_pkg::CountW-1:0] sample_inc;
  logic [mscpc_pkg::CountW-1:0] pause_tmp;

  logic                         out_valid_r;
  logic [7:0]                   out_data_r;

  assign mode      = mscpc_pkg::mode_t'(in_tuser);
  assign adc_value = in_tdata[mscpc_pkg::AdcW-1:0];
  assign low_pin   = in_tdata[mscpc_pkg::AdcW];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.battery_full      <= mscpc_pkg::RstBatteryFull;
      cfg_r.min_drive_level   <= mscpc_pkg::RstMinDriveLevel;
      cfg_r.sample_period     <= mscpc_pkg::RstSamplePeriod;
      cfg_r.low_battery_pause <= mscpc_pkg::RstLowBatteryPause;
      cfg_r.blink_period      <= mscpc_pkg::RstBlinkPeriod;
      cfg_r.led_min_on        <= mscpc_pkg::RstLedMinOn;
      cfg_r.sync_holdoff      <= mscpc_pkg::RstSyncHoldoff;
      cfg_r.phase_period      <= mscpc_pkg::RstPhasePeriod;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mscpc_pkg::reg_idx_t'(cfg_index))
        mscpc_pkg::REG_BATTERY_FULL:      cfg_r.battery_full      <= cfg_data;
        mscpc_pkg::REG_MIN_DRIVE_LEVEL:   cfg_r.min_drive_level   <= cfg_data[7:0];
        mscpc_pkg::REG_SAMPLE_PERIOD:     cfg_r.sample_period     <= cfg_data[7:0];
        mscpc_pkg::REG_LOW_BATTERY_PAUSE: cfg_r.low_battery_pause <= cfg_data[7:0];
        mscpc_pkg::REG_BLINK_PERIOD:      cfg_r.blink_period      <= cfg_data[7:0];
        mscpc_pkg::REG_LED_MIN_ON:        cfg_r.led_min_on        <= cfg_data[7:0];
        mscpc_pkg::REG_SYNC_HOLDOFF:      cfg_r.sync_holdoff      <= cfg_data[6:0];
        mscpc_pkg::REG_PHASE_PERIOD:      cfg_r.phase_period      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    latched_nxt = latched_r;
    level_nxt   = level_r;
    drive_nxt   = drive_r;
    sample_nxt  = sample_r;
    pause_nxt   = pause_r;
    batt_nxt    = batt_r;
    setp_nxt    = setp_r;
    seen_nxt    = seen_r;
    chan_nxt    = chan_r;
    synced      = 1'b0;
    phase_inc   = {1'b0, phase_r} + 8'd1;
    sample_inc  = sample_r + 8'd1;
    pause_tmp   = pause_r;
    unique case (mode)
      mscpc_pkg::MODE_TIMER: begin
        if (phase_inc == latched_r) begin
          drive_nxt = 1'b0;
        end
        if (phase_inc >= {1'b0, cfg_r.phase_period}) begin
          phase_nxt = '0;
          drive_nxt = 1'b0;
        end else begin
          phase_nxt = phase_inc[mscpc_pkg::PhaseW-1:0];
        end
      end
      mscpc_pkg::MODE_SYNC: begin
        if (phase_r > cfg_r.sync_holdoff) begin
          synced      = 1'b1;
          phase_nxt   = '0;
          latched_nxt = level_r;
          if (sample_inc > cfg_r.sample_period) begin
            sample_nxt = '0;
            pause_tmp  = 8'd1;
            seen_nxt   = 1'b1;
            chan_nxt   = 1'b1;
          end else begin
            sample_nxt = sample_inc;
            chan_nxt   = 1'b0;
          end
          if (low_pin) begin
            pause_tmp = cfg_r.low_battery_pause;
          end
          if (pause_tmp != '0) begin
            drive_nxt = 1'b0;
            pause_nxt = pause_tmp - 8'd1;
          end else begin
            drive_nxt = level_r > cfg_r.min_drive_level;
            pause_nxt = pause_tmp;
          end
          if (sample_nxt == 8'd1) begin
            batt_nxt = adc_value;
          end else begin
            setp_nxt = adc_value;
          end
        end
      end
      mscpc_pkg::MODE_MAIN: begin
        if (batt_r >= cfg_r.battery_full) begin
          level_nxt = '0;
        end else begin
          level_nxt = mscpc_pkg::div3(~setp_r[mscpc_pkg::AdcW-1:2]);
        end
        seen_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  mscpc_led u_led (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (accept && (mode == mscpc_pkg::MODE_MAIN)),
    .sync_seen      (seen_r),
    .battery_sample (batt_r),
    .cfg            (cfg_r),
    .led_on_nxt     (led_nxt)
  );

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      latched_r   <= '0;
      level_r     <= '0;
      drive_r     <= 1'b0;
      sample_r    <= '0;
      pause_r     <= mscpc_pkg::RstPauseCount;
      batt_r      <= '0;
      setp_r      <= '0;
      seen_r      <= 1'b0;
      chan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        latched_r   <= latched_nxt;
        level_r     <= level_nxt;
        drive_r     <= drive_nxt;
        sample_r    <= sample_nxt;
        pause_r     <= pause_nxt;
        batt_r      <= batt_nxt;
        setp_r      <= setp_nxt;
        seen_r      <= seen_nxt;
        chan_r      <= chan_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {4'b0000, synced, chan_nxt, led_nxt, drive_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
